FILE: design/b64_pkg.sv
package b64_pkg;

  localparam logic [6:0] SEXTET_PAD = 7'd64;
  localparam logic [6:0] SEXTET_BAD = 7'd65;
  localparam logic [7:0] PAD_CHAR   = 8'h3D;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            last;
    logic            err;
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  function automatic logic [6:0] classify(input logic [7:0] c);
    logic [6:0] v;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end else if (c == PAD_CHAR) begin
      v = SEXTET_PAD;
    end else begin
      v = SEXTET_BAD;
    end
    return v;
  endfunction

endpackage

FILE: design/base64_codec.sv
// Channel   | Dir | Signals                         | Payload
// ----------+-----+---------------------------------+-------------------------------
// s_*       | in  | s_tvalid s_tready s_tdata s_tlast | tdata[7:0] data_in, tlast last_in
// m_*       | out | m_tvalid m_tready m_tdata m_tlast m_tuser | tdata[7:0] data_out,
//           |     |                                 | tlast last_out, tuser[0] error
// cfg_*     | in  | cfg_we cfg_wdata                | direction (0 encode, 1 decode)
//
// Input takes one transaction per cycle while the job queue has room.
// Output runs one transaction per cycle from the back end while m_tready is high;
// encode gives four characters per three bytes, so the output bounds its input rate.
// A result passes through the job queue and then the back-end register to the output.
// Reset (synchronous) selects encode and empties the queue and the back end.
// Each side stalls on its own; the queue of QUEUE_DEPTH jobs sits between them.
module base64_codec
  import b64_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_in
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] data_out
  output logic       m_tlast,
  output logic       m_tuser    // [0] error
);

  job_t push_job, pop_job;
  logic push, full, pop, pop_valid;

  b64_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .queue_full (full),
    .job_valid  (push),
    .job        (push_job)
  );

  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_job   (pop_job)
  );

  b64_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (pop_valid),
    .q_job    (pop_job),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: design/b64_front.sv
module b64_front
  import b64_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       queue_full,
  output logic       job_valid,
  output job_t       job
);

  logic        direction;
  logic [17:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic        error_seen, error_seen_next;
  logic        pad_third, pad_third_next;
  logic        pad_closed, pad_closed_next;

  logic        accept;
  logic [23:0] enc_word;
  logic [23:0] dec_word;
  logic [6:0]  cls;
  logic [5:0]  sext;
  logic        is_pad, is_bad, pad_fourth, dec_err;
  logic [2:0]  enc_nbytes;

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    group_bits_next  = group_bits;
    group_count_next = group_count;
    error_seen_next  = error_seen;
    pad_third_next   = pad_third;
    pad_closed_next  = pad_closed;
    job_valid        = 1'b0;
    job              = '0;

    case (group_count)
      2'd2:    enc_word = {group_bits[15:0], s_tdata};
      2'd1:    enc_word = {group_bits[7:0], s_tdata, 8'h00};
      default: enc_word = {s_tdata, 16'h0000};
    endcase
    enc_nbytes = {1'b0, group_count} + 3'd1;

    cls        = classify(s_tdata);
    is_pad     = (cls == SEXTET_PAD);
    is_bad     = (cls == SEXTET_BAD);
    sext       = (is_pad || is_bad) ? 6'd0 : cls[5:0];
    pad_fourth = is_pad && (group_count == 2'd3);
    dec_err    = error_seen || pad_closed || is_bad ||
                 (is_pad && group_count < 2'd2) ||
                 (!is_pad && !is_bad && group_count == 2'd3 && pad_third);
    dec_word   = {group_bits, sext};

    if (accept) begin
      if (!direction) begin
        if (group_count < 2'd2 && !s_tlast) begin
          group_bits_next  = {group_bits[9:0], s_tdata};
          group_count_next = group_count + 2'd1;
        end else begin
          job_valid    = 1'b1;
          job.last_idx = 2'd3;
          job.last     = s_tlast;
          for (int k = 0; k < 4; k++) begin
            job.bytes[k] = (3'(k) <= enc_nbytes) ?
                           sextet_char(enc_word[23-6*k -: 6]) : PAD_CHAR;
          end
          group_bits_next  = '0;
          group_count_next = '0;
        end
      end else begin
        if (group_count < 2'd3) begin
          if (s_tlast) begin
            job_valid    = 1'b1;
            job.last_idx = 2'd0;
            job.last     = 1'b1;
            job.err      = 1'b1;
          end else begin
            group_bits_next  = {group_bits[11:0], sext};
            group_count_next = group_count + 2'd1;
            error_seen_next  = dec_err;
            pad_third_next   = pad_third || (is_pad && group_count == 2'd2);
          end
        end else begin
          job_valid    = 1'b1;
          job.bytes[0] = dec_word[23:16];
          job.bytes[1] = dec_word[15:8];
          job.bytes[2] = dec_word[7:0];
          job.last_idx = pad_fourth ? (pad_third ? 2'd0 : 2'd1) : 2'd2;
          job.last     = s_tlast;
          job.err      = dec_err;
          group_bits_next  = '0;
          group_count_next = '0;
          pad_third_next   = 1'b0;
          error_seen_next  = dec_err;
          pad_closed_next  = pad_closed || pad_fourth;
        end
      end
      if (s_tlast) begin
        group_bits_next  = '0;
        group_count_next = '0;
        error_seen_next  = 1'b0;
        pad_third_next   = 1'b0;
        pad_closed_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= 1'b0;
      group_bits  <= '0;
      group_count <= '0;
      error_seen  <= 1'b0;
      pad_third   <= 1'b0;
      pad_closed  <= 1'b0;
    end else if (cfg_we) begin
      direction   <= cfg_wdata;
      group_bits  <= '0;
      group_count <= '0;
      error_seen  <= 1'b0;
      pad_third   <= 1'b0;
      pad_closed  <= 1'b0;
    end else begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      error_seen  <= error_seen_next;
      pad_third   <= pad_third_next;
      pad_closed  <= pad_closed_next;
    end
  end

endmodule

FILE: design/b64_queue.sv
module b64_queue
  import b64_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output job_t pop_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full      = (count == FULL_CNT);
  assign pop_valid = (count != '0);
  assign pop_job   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: design/b64_back.sv
module b64_back
  import b64_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic       m_tuser
);

  job_t       cur;
  logic       busy;
  logic [1:0] idx;
  logic       fin, is_last;

  assign fin     = (idx == cur.last_idx);
  assign q_pop   = q_valid && (!busy || (m_tready && fin));
  assign is_last = cur.last && fin;

  assign m_tvalid = busy;
  assign m_tdata  = cur.bytes[idx];
  assign m_tlast  = is_last;
  assign m_tuser  = is_last && cur.err;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && m_tready) begin
      if (fin) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

FILE: design/b64_checker.sv
module b64_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    else $error("output payload changed while stalled");

  a_error_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("error flagged on a non-final result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind base64_codec b64_checker u_chk (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam logic       DIR_ENCODE  = 1'b0;
  localparam logic       DIR_DECODE  = 1'b1;
  localparam logic [6:0] SX_PAD      = 7'd64;
  localparam logic [6:0] SX_BAD      = 7'd65;
  localparam logic [7:0] EQ_CHAR     = 8'h3D;
  localparam int         ITEM_TARGET = 500;
  localparam int         SETTLE_CYC  = 10;
  localparam int         TAIL_CYC    = 20;

  localparam int READY_ALWAYS = 0;
  localparam int READY_COIN   = 1;
  localparam int READY_SPARSE = 2;
  localparam int READY_BEAT   = 3;

  typedef enum logic [1:0] {OP_BYTE, OP_CFG, OP_DRAIN} feed_op_e;

  typedef struct {
    feed_op_e   op;
    logic [7:0] data;
    logic       last;
  } feed_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       err;
  } codec_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;  // [7:0] data_in
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // [7:0] data_out
  logic       m_tlast;
  logic       m_tuser;          // [0] error

  feed_item_t feed_items[$];
  codec_out_t due_codes[$];
  int         queued = 0;
  int         fail_count = 0;
  logic       in_taken = 1'b0;

  logic        cur_dir = DIR_ENCODE;
  logic [17:0] grp_bits = '0;
  logic [1:0]  grp_cnt = '0;
  logic        err_seen = 1'b0;
  logic        pad_third = 1'b0;
  logic        pad_closed = 1'b0;

  base64_codec DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [7:0] sextet_char_of(input logic [5:0] v);
    if (v < 6'd26) begin
      return "A" + {2'b00, v};
    end else if (v < 6'd52) begin
      return "a" + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      return "0" + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      return "+";
    end
    return "/";
  endfunction

  function automatic logic [6:0] char_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return 7'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      return 7'(c - "a" + 8'd26);
    end else if (c >= "0" && c <= "9") begin
      return 7'(c - "0" + 8'd52);
    end else if (c == "+") begin
      return 7'd62;
    end else if (c == "/") begin
      return 7'd63;
    end else if (c == EQ_CHAR) begin
      return SX_PAD;
    end
    return SX_BAD;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic emit(input logic [7:0] d, input logic l, input logic e);
    codec_out_t r;
    r.data = d;
    r.last = l;
    r.err  = e;
    due_codes.insert(due_codes.size(), r);
  endtask

  task automatic clear_stream();
    grp_bits   = '0;
    grp_cnt    = '0;
    err_seen   = 1'b0;
    pad_third  = 1'b0;
    pad_closed = 1'b0;
  endtask

  task automatic codec_advance(input logic [7:0] d, input logic l);
    logic [23:0] word;
    logic [6:0]  v;
    logic [5:0]  s;
    logic        pad_fourth;
    logic        fin;
    int          nbytes;
    int          k;
    if (cur_dir == DIR_ENCODE) begin
      if (grp_cnt < 2'd2 && !l) begin
        grp_bits = {grp_bits[9:0], d};
        grp_cnt  = grp_cnt + 2'd1;
      end else begin
        nbytes = int'(grp_cnt) + 1;
        case (grp_cnt)
          2'd0:    word = {d, 16'h0000};
          2'd1:    word = {grp_bits[7:0], d, 8'h00};
          default: word = {grp_bits[15:0], d};
        endcase
        for (k = 0; k < 4; k++) begin
          emit((k <= nbytes) ? sextet_char_of(word[23 - 6 * k -: 6]) : EQ_CHAR,
               l && k == 3, 1'b0);
        end
        if (l) begin
          clear_stream();
        end else begin
          grp_bits = '0;
          grp_cnt  = '0;
        end
      end
    end else begin
      v = char_value(d);
      s = v[5:0];
      pad_fourth = 1'b0;
      if (pad_closed) err_seen = 1'b1;
      if (v == SX_BAD) begin
        err_seen = 1'b1;
        s = '0;
      end else if (v == SX_PAD) begin
        s = '0;
        if (grp_cnt < 2'd2) err_seen = 1'b1;
        else if (grp_cnt == 2'd2) pad_third = 1'b1;
        else pad_fourth = 1'b1;
      end else if (grp_cnt == 2'd3 && pad_third) begin
        err_seen = 1'b1;
      end
      if (grp_cnt < 2'd3) begin
        if (l) begin
          emit(8'h00, 1'b1, 1'b1);
          clear_stream();
        end else begin
          grp_bits = {grp_bits[11:0], s};
          grp_cnt  = grp_cnt + 2'd1;
        end
      end else begin
        word   = {grp_bits, s};
        nbytes = pad_fourth ? (pad_third ? 1 : 2) : 3;
        if (pad_fourth) pad_closed = 1'b1;
        for (k = 0; k < nbytes; k++) begin
          fin = l && (k + 1 == nbytes);
          emit(word[23 - 8 * k -: 8], fin, fin && err_seen);
        end
        if (l) begin
          clear_stream();
        end else begin
          grp_bits  = '0;
          grp_cnt   = '0;
          pad_third = 1'b0;
        end
      end
    end
  endtask

  task automatic queue_byte(input logic [7:0] d, input logic l);
    feed_item_t it;
    it.op   = OP_BYTE;
    it.data = d;
    it.last = l;
    feed_items.insert(feed_items.size(), it);
    queued++;
  endtask

  task automatic queue_ctrl(input feed_op_e op, input logic v);
    feed_item_t it;
    it.op   = op;
    it.data = {7'd0, v};
    it.last = 1'b0;
    feed_items.insert(feed_items.size(), it);
  endtask

  task automatic add_text(input string txt, input logic end_it);
    int i;
    for (i = 0; i < txt.len(); i++) begin
      queue_byte(txt[i], end_it && i == txt.len() - 1);
    end
  endtask

  task automatic add_raw(input int n, input logic end_it);
    logic [7:0] fill;
    int         mode;
    int         i;
    mode = $urandom_range(0, 9);
    fill = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    for (i = 0; i < n; i++) begin
      queue_byte((mode == 0) ? fill : 8'($urandom_range(0, 255)), end_it && i == n - 1);
    end
  endtask

  task automatic add_encoded(input int nbytes, input logic end_it, input logic corrupt);
    logic [7:0]  raw[$];
    logic [7:0]  txt[$];
    logic [23:0] w;
    int          i;
    int          k;
    int          take;
    for (i = 0; i < nbytes + 2; i++) begin
      raw.insert(raw.size(), (i < nbytes) ? 8'($urandom_range(0, 255)) : 8'h00);
    end
    for (i = 0; i < nbytes; i += 3) begin
      take = (nbytes - i > 3) ? 3 : nbytes - i;
      w = {raw[i], raw[i + 1], raw[i + 2]};
      for (k = 0; k < 4; k++) begin
        txt.insert(txt.size(),
                   (k <= take) ? sextet_char_of(w[23 - 6 * k -: 6]) : EQ_CHAR);
      end
    end
    if (corrupt) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
    for (i = 0; i < txt.size(); i++) begin
      queue_byte(txt[i], end_it && i == txt.size() - 1);
    end
  endtask

  task automatic add_noise(input int n, input logic end_it);
    logic [7:0] c;
    int         i;
    int         pick;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) c = sextet_char_of(6'($urandom_range(0, 63)));
      else if (pick < 15) c = EQ_CHAR;
      else c = 8'($urandom_range(0, 255));
      queue_byte(c, end_it && i == n - 1);
    end
  endtask

  // sender: hold until accepted, then advance through the feed queue
  always @(negedge clk) begin : drive_input
    int         gap_left;
    int         burst_left;
    int         settle;
    logic       nxt_valid;
    logic [7:0] nxt_data;
    logic       nxt_last;
    logic       nxt_we;
    logic       nxt_wdata;
    nxt_valid = s_tvalid;
    nxt_data  = s_tdata;
    nxt_last  = s_tlast;
    nxt_we    = 1'b0;
    nxt_wdata = cfg_wdata;
    if (!rst && !(s_tvalid && !in_taken)) begin
      nxt_valid = 1'b0;
      if (feed_items.size() != 0) begin
        if (feed_items[0].op == OP_BYTE) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            nxt_valid = 1'b1;
            nxt_data  = feed_items[0].data;
            nxt_last  = feed_items[0].last;
            void'(feed_items.pop_front());
            if (burst_left <= 1) begin
              burst_left = $urandom_range(1, 24);
              gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
              burst_left--;
            end
          end
        end else if (due_codes.size() != 0) begin
          settle = 0;
        end else if (settle < SETTLE_CYC) begin
          settle++;
        end else begin
          if (feed_items[0].op == OP_CFG) begin
            nxt_we    = 1'b1;
            nxt_wdata = feed_items[0].data[0];
          end
          void'(feed_items.pop_front());
          settle = 0;
        end
      end
    end
    s_tvalid  <= nxt_valid;
    s_tdata   <= nxt_data;
    s_tlast   <= nxt_last;
    cfg_we    <= nxt_we;
    cfg_wdata <= nxt_wdata;
  end

  always @(negedge clk) begin : drive_ready
    int mode;
    int hold;
    int beat;
    if (hold <= 0) begin
      mode = $urandom_range(READY_ALWAYS, READY_BEAT);
      hold = $urandom_range(20, 120);
    end else begin
      hold--;
    end
    beat++;
    case (mode)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
      READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:      m_tready <= (beat % 3 != 0);
    endcase
  end

  always @(posedge clk) begin : watch_ports
    codec_out_t want;
    in_taken = 1'b0;
    if (!rst) begin
      if (cfg_we) begin
        cur_dir = cfg_wdata;
        clear_stream();
      end
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        codec_advance(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (due_codes.size() == 0) begin
          flag_mismatch($sformatf("unexpected transaction data=%02h last=%0b err=%0b",
                                  m_tdata, m_tlast, m_tuser));
        end else begin
          want = due_codes.pop_front();
          if (m_tdata !== want.data)
            flag_mismatch($sformatf("data %02h, want %02h", m_tdata, want.data));
          if (m_tlast !== want.last)
            flag_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
          if (m_tuser !== want.err)
            flag_mismatch($sformatf("error %0b, want %0b", m_tuser, want.err));
        end
      end
    end
  end

  initial begin : stimulus
    int   phase;
    int   stop_at;
    int   pick;
    logic want_dir;

    queue_ctrl(OP_CFG, DIR_ENCODE);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'h7F, 1'b1);
    queue_ctrl(OP_CFG, DIR_DECODE);
    add_text("TWE=", 1'b0);
    add_text("TWFu", 1'b1);
    add_text("AB=C", 1'b1);
    queue_byte(EQ_CHAR, 1'b0);
    queue_byte("z", 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte("/", 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte("9", 1'b1);

    phase = 0;
    while (queued < ITEM_TARGET) begin
      want_dir = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
      queue_ctrl(OP_CFG, want_dir);
      stop_at = queued + $urandom_range(50, 90);
      while (queued < stop_at) begin
        if (want_dir == DIR_ENCODE) begin
          add_raw($urandom_range(1, 10), 1'b1);
        end else begin
          pick = $urandom_range(0, 7);
          if (pick < 5) begin
            add_encoded($urandom_range(1, 9), 1'b1, 1'b0);
          end else if (pick == 5) begin
            add_encoded($urandom_range(1, 9), 1'b1, 1'b1);
          end else if (pick == 6) begin
            add_encoded($urandom_range(1, 5), 1'b0, 1'b0);
            add_encoded($urandom_range(1, 5), 1'b1, 1'b0);
          end else begin
            add_noise($urandom_range(1, 9), 1'b1);
          end
        end
        if ($urandom_range(0, 15) == 0) queue_ctrl(OP_DRAIN, 1'b0);
      end
      // leave a stream open so the next register write has to clear it
      if ($urandom_range(0, 1) == 1) begin
        if (want_dir == DIR_ENCODE) add_raw($urandom_range(1, 2), 1'b0);
        else add_noise($urandom_range(1, 3), 1'b0);
      end
      phase++;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (feed_items.size() != 0 || s_tvalid || due_codes.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
